// ===== src/vma_pkg.sv =====
// Shared types and constants for the vector moving average block.
// Holds the payload structs, controller state codes and the command/status bundles.
// No dependencies.
package vma_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int CFG_BITS     = 5;
	localparam int RESET_WINDOW = 8;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x_in;
		logic signed [SAMPLE_BITS-1:0] y_in;
		logic signed [SAMPLE_BITS-1:0] z_in;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x_avg;
		logic signed [SAMPLE_BITS-1:0] y_avg;
		logic signed [SAMPLE_BITS-1:0] z_avg;
	} avg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT,
		ST_ADD,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic evict;
		logic add;
		logic load;
		logic step;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== src/vma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the sample ring. No package dependencies.
module vma_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/vma_ctrl.sv =====
// Sequencing controller for the moving average: capture, evict, add, divide, emit.
// Depends on vma_pkg for the state codes and the command/status structs.
module vma_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	output logic              cfg_ready,
	input  vma_pkg::ctl_sts_t sts,
	output vma_pkg::ctl_cmd_t cmd
);

	vma_pkg::state_t state_q;
	vma_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vma_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			vma_pkg::ST_IDLE: begin
				if (sample_valid) state_next = vma_pkg::ST_EVICT;
			end
			vma_pkg::ST_EVICT: begin
				state_next = vma_pkg::ST_ADD;
			end
			vma_pkg::ST_ADD: begin
				state_next = vma_pkg::ST_LOAD;
			end
			vma_pkg::ST_LOAD: begin
				state_next = vma_pkg::ST_DIV;
			end
			vma_pkg::ST_DIV: begin
				if (sts.div_done) state_next = vma_pkg::ST_OUT;
			end
			vma_pkg::ST_OUT: begin
				if (sts.out_free) state_next = vma_pkg::ST_IDLE;
			end
			default: begin
				state_next = vma_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_stall = 1'b1;
		cfg_ready    = 1'b0;
		unique case (state_q)
			vma_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				// hold off a register write while a sample is being taken
				cfg_ready    = !sample_valid;
				cmd.capture  = sample_valid;
			end
			vma_pkg::ST_EVICT: cmd.evict = 1'b1;
			vma_pkg::ST_ADD:   cmd.add   = 1'b1;
			vma_pkg::ST_LOAD:  cmd.load  = 1'b1;
			vma_pkg::ST_DIV:   cmd.step  = 1'b1;
			vma_pkg::ST_OUT:   cmd.emit  = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== src/vma_datapath.sv =====
// Datapath: window counters, running sums, sample ring, three-lane restoring divider
// and the output register. Depends on vma_pkg and vma_ram.
module vma_datapath #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vma_pkg::sample_t                 sample,
	input  logic                             cfg_we,
	input  logic [vma_pkg::CFG_BITS-1:0]     cfg_data,
	input  vma_pkg::ctl_cmd_t                cmd,
	output vma_pkg::ctl_sts_t                sts,
	output vma_pkg::avg_t                    avg,
	output logic                             avg_valid,
	input  logic                             avg_stall
);

	localparam int SB   = vma_pkg::SAMPLE_BITS;
	localparam int CFGW = vma_pkg::CFG_BITS;
	localparam int CW   = $clog2(MAX_WINDOW + 1);
	localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUMW = SB + CW;
	localparam int DCW  = $clog2(SUMW);
	localparam int WW   = (CW > CFGW) ? CW : CFGW;
	localparam int RW   = 3 * SB;
	localparam logic [CW-1:0] MAXW      = CW'(MAX_WINDOW);
	localparam logic [CW-1:0] RESET_WIN =
		(vma_pkg::RESET_WINDOW > MAX_WINDOW) ? MAXW : CW'(vma_pkg::RESET_WINDOW);
	localparam logic [DCW-1:0] LAST_STEP = DCW'(SUMW - 1);

	logic [CW-1:0]          win_q;
	logic [CW-1:0]          fill_q;
	logic [AW-1:0]          oldest_q;
	logic signed [SUMW-1:0] sums_q [3];
	vma_pkg::sample_t       samp_q;
	logic [AW-1:0]          slot_q;
	logic                   full_q;
	logic                   neg_q  [3];
	logic [SUMW-1:0]        quot_q [3];
	logic [CW-1:0]          rem_q  [3];
	logic [DCW-1:0]         dcnt_q;
	vma_pkg::avg_t          avg_q;
	logic                   avg_valid_q;

	logic [WW-1:0]          cfg_wide;
	logic [CW-1:0]          win_cfg;
	logic                   full;
	logic [AW-1:0]          slot;
	vma_pkg::sample_t       old_samp;
	logic signed [SB-1:0]   new_c  [3];
	logic signed [SB-1:0]   old_c  [3];
	logic [SUMW-1:0]        mag    [3];
	logic [CW:0]            trial  [3];
	logic                   ge     [3];
	logic [CW-1:0]          rem_nx [3];
	logic [SUMW-1:0]        res    [3];

	// Effective window: zero means one, oversize saturates.
	assign cfg_wide = WW'(cfg_data);
	assign win_cfg  = (cfg_data == '0) ? CW'(1) :
		((cfg_wide > WW'(MAX_WINDOW)) ? MAXW : CW'(cfg_wide));

	assign full = (fill_q == win_q);
	assign slot = full ? oldest_q : fill_q[AW-1:0];

	vma_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.add),
		.waddr (slot_q),
		.wdata (samp_q),
		.re    (cmd.capture),
		.raddr (slot),
		.rdata (old_samp)
	);

	assign new_c[0] = samp_q.x_in;
	assign new_c[1] = samp_q.y_in;
	assign new_c[2] = samp_q.z_in;
	assign old_c[0] = old_samp.x_in;
	assign old_c[1] = old_samp.y_in;
	assign old_c[2] = old_samp.z_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i]    = sums_q[i][SUMW-1] ? $unsigned(-sums_q[i]) : $unsigned(sums_q[i]);
			trial[i]  = {rem_q[i], quot_q[i][SUMW-1]};
			ge[i]     = (trial[i] >= {1'b0, fill_q});
			rem_nx[i] = ge[i] ? CW'(trial[i] - {1'b0, fill_q}) : trial[i][CW-1:0];
			res[i]    = neg_q[i] ? (~quot_q[i] + SUMW'(1)) : quot_q[i];
		end
	end

	// Window bookkeeping; a register write restarts the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= RESET_WIN;
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (cfg_we) begin
			win_q    <= win_cfg;
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (cmd.add) begin
			if (full_q) begin
				oldest_q <= ((CW'(oldest_q) + CW'(1)) == win_q) ? '0 : oldest_q + AW'(1);
			end else begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) sums_q[i] <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < 3; i++) sums_q[i] <= '0;
		end else if (cmd.evict && full_q) begin
			for (int i = 0; i < 3; i++) sums_q[i] <= sums_q[i] - SUMW'(old_c[i]);
		end else if (cmd.add) begin
			for (int i = 0; i < 3; i++) sums_q[i] <= sums_q[i] + SUMW'(new_c[i]);
		end
	end

	// Hold the sample and its ring slot for the duration of the item.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			samp_q <= sample;
			slot_q <= slot;
			full_q <= full;
		end
	end

	// Divide magnitudes one quotient bit per cycle in each lane.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				neg_q[i]  <= sums_q[i][SUMW-1];
				quot_q[i] <= mag[i];
				rem_q[i]  <= '0;
			end
		end else if (cmd.step) begin
			for (int i = 0; i < 3; i++) begin
				quot_q[i] <= {quot_q[i][SUMW-2:0], ge[i]};
				rem_q[i]  <= rem_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.load) begin
			dcnt_q <= '0;
		end else if (cmd.step) begin
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			avg_q.x_avg <= res[0][SB-1:0];
			avg_q.y_avg <= res[1][SB-1:0];
			avg_q.z_avg <= res[2][SB-1:0];
		end
	end

	// Drop valid once the transfer completes unless a new result lands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			avg_valid_q <= 1'b1;
		end else if (!avg_stall) begin
			avg_valid_q <= 1'b0;
		end
	end

	assign sts.div_done = (dcnt_q == LAST_STEP);
	assign sts.out_free = !avg_valid_q || !avg_stall;
	assign avg          = avg_q;
	assign avg_valid    = avg_valid_q;

endmodule

// ===== src/vector_moving_average.sv =====
// Top level of the vector moving average: boxcar mean over three-component samples.
// Instantiates vma_ctrl and vma_datapath; depends on vma_pkg.
//
//   channel   handshake                  payload              direction
//   sample    sample_valid/sample_stall  vma_pkg::sample_t    in
//   avg       avg_valid/avg_stall        vma_pkg::avg_t       out
//   cfg       cfg_valid/cfg_ready        cfg_data (5 bits)    in
//
// A new sample is taken only once the previous one has passed the bit-serial divider,
// which runs all three components side by side, and has been emitted. A finished result
// sits in the output register, so the next sample is taken while it still waits; that
// sample's result then holds in the last state until the output is free. Reset restores
// a window of eight and empties the window; the ring needs no clearing. cfg_ready is
// high only between samples and drops while a sample is offered.
module vector_moving_average #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  vma_pkg::sample_t             sample,
	output logic                         avg_valid,
	input  logic                         avg_stall,
	output vma_pkg::avg_t                avg,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [vma_pkg::CFG_BITS-1:0] cfg_data
);

	vma_pkg::ctl_cmd_t cmd;
	vma_pkg::ctl_sts_t sts;
	logic              cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	vma_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.cfg_ready    (cfg_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	vma_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.avg       (avg),
		.avg_valid (avg_valid),
		.avg_stall (avg_stall)
	);

endmodule
